[design/midi_track_event_parser_defines.svh]
// Assertion helpers for the track event parser checker.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MTEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mtep_pkg.sv]
package mtep_pkg;

  localparam int HEADER_BYTES = 14;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 2);

  localparam int DELTA_W = 28;
  localparam int TRACK_W = 32;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] META_STATUS = 8'hFF;

  typedef enum logic [1:0] {
    KIND_CHAN = 2'd0,
    KIND_META = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_TAG    = 2'd1,
    ERR_STATUS = 2'd2
  } err_t;

  typedef struct packed {
    kind_t                kind;
    err_t                 error_code;
    logic [DELTA_W-1:0]   delta_ticks;
    logic [7:0]           status_byte;
    logic [7:0]           first_data;
    logic [7:0]           second_data;
    logic [7:0]           meta_kind;
    logic [DELTA_W-1:0]   meta_size;
    logic                 track_end;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } rec_push_t;

  function automatic logic [7:0] chunk_tag(input logic [1:0] idx);
    logic [7:0] tag;
    unique case (idx)
      2'd0: tag = 8'h4D;
      2'd1: tag = 8'h54;
      2'd2: tag = 8'h72;
      2'd3: tag = 8'h6B;
      default: tag = 8'h00;
    endcase
    return tag;
  endfunction

  function automatic logic is_chan_status(input logic [7:0] b);
    return (b[7:4] >= 4'h8) && (b[7:4] <= 4'hE);
  endfunction

  function automatic logic is_one_data(input logic [7:0] s);
    return (s[7:4] == 4'hC) || (s[7:4] == 4'hD);
  endfunction

endpackage

[design/mtep_byte_if.sv]
interface mtep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[design/mtep_rec_if.sv]
interface mtep_rec_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [1:0]                    error_code;
  logic [mtep_pkg::DELTA_W-1:0]  delta_ticks;
  logic [7:0]                    status_byte;
  logic [7:0]                    first_data;
  logic [7:0]                    second_data;
  logic [7:0]                    meta_kind;
  logic [mtep_pkg::DELTA_W-1:0]  meta_size;
  logic                          track_end;

  modport source (output valid, output kind, output error_code, output delta_ticks,
                  output status_byte, output first_data, output second_data,
                  output meta_kind, output meta_size, output track_end, input ready);
  modport sink   (input valid, input kind, input error_code, input delta_ticks,
                  input status_byte, input first_data, input second_data,
                  input meta_kind, input meta_size, input track_end, output ready);
endinterface

[design/mtep_front.sv]
module mtep_front (
  input  logic                clk,
  input  logic                rst_n,
  mtep_byte_if.sink           in_ch,
  input  logic                q_full,
  output mtep_pkg::rec_push_t q_wr
);

  typedef enum logic [9:0] {
    PH_HEADER = 10'b0000000001,
    PH_TAG    = 10'b0000000010,
    PH_LEN    = 10'b0000000100,
    PH_DELTA  = 10'b0000001000,
    PH_STATUS = 10'b0000010000,
    PH_DATA1  = 10'b0000100000,
    PH_DATA2  = 10'b0001000000,
    PH_MTYPE  = 10'b0010000000,
    PH_MLEN   = 10'b0100000000,
    PH_MSKIP  = 10'b1000000000
  } phase_t;

  localparam phase_t PH_RESET = (mtep_pkg::HEADER_BYTES == 0) ? PH_TAG : PH_HEADER;
  localparam int     DW       = mtep_pkg::DELTA_W;
  localparam int     TW       = mtep_pkg::TRACK_W;

  phase_t                           phase_r, phase_nxt;
  logic [1:0]                       field_cnt_r, field_cnt_nxt;
  logic [mtep_pkg::HDR_CNT_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [TW-1:0]                    track_rem_r, track_rem_nxt;
  logic [DW-1:0]                    delta_r, delta_nxt;
  logic [7:0]                       status_r, status_nxt;
  logic [7:0]                       data_r, data_nxt;
  logic [7:0]                       mtype_r, mtype_nxt;
  logic [DW-1:0]                    skip_r, skip_nxt;
  logic [DW-1:0]                    msize_r, msize_nxt;
  logic                             halted_r, halted_nxt;

  logic                             accept;
  logic                             in_body;
  logic [TW-1:0]                    tr_dec;
  logic                             tend;
  logic [7:0]                       b;
  logic [DW-1:0]                    delta_shift;
  logic [DW-1:0]                    skip_shift;
  logic [DW-1:0]                    skip_dec;
  logic [TW-1:0]                    len_shift;
  mtep_pkg::rec_t                   chan_rec, meta_rec;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;

  assign in_body = (phase_r == PH_DELTA) || (phase_r == PH_STATUS) ||
                   (phase_r == PH_DATA1) || (phase_r == PH_DATA2) ||
                   (phase_r == PH_MTYPE) || (phase_r == PH_MLEN) ||
                   (phase_r == PH_MSKIP);
  assign tr_dec      = (in_body && (track_rem_r != '0)) ? track_rem_r - TW'(1) : track_rem_r;
  assign tend        = (tr_dec == '0);
  assign delta_shift = {delta_r[DW-8:0], b[6:0]};
  assign skip_shift  = {skip_r[DW-8:0], b[6:0]};
  assign skip_dec    = (skip_r != '0) ? skip_r - DW'(1) : skip_r;
  assign len_shift   = {track_rem_r[TW-9:0], b};

  always_comb begin
    chan_rec             = '0;
    chan_rec.kind        = mtep_pkg::KIND_CHAN;
    chan_rec.error_code  = mtep_pkg::ERR_NONE;
    chan_rec.delta_ticks = delta_r;
    chan_rec.status_byte = status_r;
    chan_rec.track_end   = tend;
    meta_rec             = '0;
    meta_rec.kind        = mtep_pkg::KIND_META;
    meta_rec.error_code  = mtep_pkg::ERR_NONE;
    meta_rec.delta_ticks = delta_r;
    meta_rec.status_byte = mtep_pkg::META_STATUS;
    meta_rec.meta_kind   = mtype_r;
    meta_rec.meta_size   = msize_r;
    meta_rec.track_end   = tend;
  end

  always_comb begin
    phase_nxt     = phase_r;
    field_cnt_nxt = field_cnt_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    track_rem_nxt = track_rem_r;
    delta_nxt     = delta_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    mtype_nxt     = mtype_r;
    skip_nxt      = skip_r;
    msize_nxt     = msize_r;
    halted_nxt    = halted_r;
    q_wr          = '0;

    if (accept && !halted_r) begin
      track_rem_nxt = tr_dec;
      unique case (phase_r)
        PH_HEADER: begin
          if (32'(hdr_cnt_r) + 32'd1 >= 32'(mtep_pkg::HEADER_BYTES)) begin
            hdr_cnt_nxt = '0;
            phase_nxt   = PH_TAG;
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 1'b1;
          end
        end
        PH_TAG: begin
          if (b != mtep_pkg::chunk_tag(field_cnt_r)) begin
            q_wr.push           = 1'b1;
            q_wr.rec.kind       = mtep_pkg::KIND_ERR;
            q_wr.rec.error_code = mtep_pkg::ERR_TAG;
            halted_nxt          = 1'b1;
          end else begin
            field_cnt_nxt = field_cnt_r + 2'd1;
            if (field_cnt_r == 2'd3) begin
              track_rem_nxt = '0;
              phase_nxt     = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          track_rem_nxt = len_shift;
          field_cnt_nxt = field_cnt_r + 2'd1;
          if (field_cnt_r == 2'd3) begin
            delta_nxt = '0;
            phase_nxt = (len_shift == '0) ? PH_TAG : PH_DELTA;
          end
        end
        PH_DELTA: begin
          delta_nxt = delta_shift;
          if (!b[7]) begin
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b == mtep_pkg::META_STATUS) begin
            status_nxt = b;
            phase_nxt  = PH_MTYPE;
          end else if (mtep_pkg::is_chan_status(b)) begin
            status_nxt = b;
            phase_nxt  = PH_DATA1;
          end else begin
            q_wr.push            = 1'b1;
            q_wr.rec.kind        = mtep_pkg::KIND_ERR;
            q_wr.rec.error_code  = mtep_pkg::ERR_STATUS;
            q_wr.rec.delta_ticks = delta_r;
            q_wr.rec.status_byte = b;
            halted_nxt           = 1'b1;
          end
        end
        PH_DATA1: begin
          if (mtep_pkg::is_one_data(status_r)) begin
            q_wr.push           = 1'b1;
            q_wr.rec            = chan_rec;
            q_wr.rec.first_data = b;
            delta_nxt           = '0;
            phase_nxt           = tend ? PH_TAG : PH_DELTA;
          end else begin
            data_nxt  = b;
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          q_wr.push            = 1'b1;
          q_wr.rec             = chan_rec;
          q_wr.rec.first_data  = data_r;
          q_wr.rec.second_data = b;
          delta_nxt            = '0;
          phase_nxt            = tend ? PH_TAG : PH_DELTA;
        end
        PH_MTYPE: begin
          mtype_nxt = b;
          skip_nxt  = '0;
          phase_nxt = PH_MLEN;
        end
        PH_MLEN: begin
          skip_nxt = skip_shift;
          if (!b[7]) begin
            msize_nxt = skip_shift;
            if (skip_shift == '0) begin
              q_wr.push              = 1'b1;
              q_wr.rec               = meta_rec;
              q_wr.rec.meta_size     = '0;
              delta_nxt              = '0;
              phase_nxt              = tend ? PH_TAG : PH_DELTA;
            end else begin
              phase_nxt = PH_MSKIP;
            end
          end
        end
        PH_MSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            q_wr.push = 1'b1;
            q_wr.rec  = meta_rec;
            delta_nxt = '0;
            phase_nxt = tend ? PH_TAG : PH_DELTA;
          end
        end
        default: begin
          phase_nxt = PH_TAG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RESET;
      field_cnt_r <= '0;
      hdr_cnt_r   <= '0;
      track_rem_r <= '0;
      delta_r     <= '0;
      status_r    <= '0;
      data_r      <= '0;
      mtype_r     <= '0;
      skip_r      <= '0;
      msize_r     <= '0;
      halted_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      field_cnt_r <= field_cnt_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      track_rem_r <= track_rem_nxt;
      delta_r     <= delta_nxt;
      status_r    <= status_nxt;
      data_r      <= data_nxt;
      mtype_r     <= mtype_nxt;
      skip_r      <= skip_nxt;
      msize_r     <= msize_nxt;
      halted_r    <= halted_nxt;
    end
  end

endmodule

[design/mtep_queue.sv]
module mtep_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  mtep_pkg::rec_push_t q_wr,
  output logic                q_full,
  output logic                q_valid,
  output mtep_pkg::rec_t      q_rec,
  input  logic                q_pop
);

  localparam int PW = mtep_pkg::QPTR_W;
  localparam int CW = mtep_pkg::QCNT_W;

  mtep_pkg::rec_t          mem_r [mtep_pkg::QDEPTH];
  logic [PW-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign q_full  = (cnt_r == CW'(mtep_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_rec   = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(mtep_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(mtep_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[design/mtep_back.sv]
module mtep_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  mtep_pkg::rec_t q_rec,
  output logic           q_pop,
  mtep_rec_if.source     out_ch
);

  logic           out_valid_r, out_valid_nxt;
  mtep_pkg::rec_t out_rec_r;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_rec_r <= q_rec;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_rec_r.kind;
  assign out_ch.error_code  = out_rec_r.error_code;
  assign out_ch.delta_ticks = out_rec_r.delta_ticks;
  assign out_ch.status_byte = out_rec_r.status_byte;
  assign out_ch.first_data  = out_rec_r.first_data;
  assign out_ch.second_data = out_rec_r.second_data;
  assign out_ch.meta_kind   = out_rec_r.meta_kind;
  assign out_ch.meta_size   = out_rec_r.meta_size;
  assign out_ch.track_end   = out_rec_r.track_end;

endmodule

[design/midi_track_event_parser.sv]
// Channel   Dir  Transaction  Payload
// in_ch     in   valid/ready  in_byte (8), one raw file byte
// out_ch    out  valid/ready  event or error record, at most one per byte
//
// One byte per cycle while in_ch is ready; the parser updates its state per byte.
// A record reaches out_ch through a four-entry record queue and an output register.
// rst_n is synchronous; after an error record the parser drops bytes until reset.
// in_ch stalls only when the record queue is full.
module midi_track_event_parser (
  input  logic       clk,
  input  logic       rst_n,
  mtep_byte_if.sink  in_ch,
  mtep_rec_if.source out_ch
);

  mtep_pkg::rec_push_t q_wr;
  logic                q_full;
  logic                q_valid;
  mtep_pkg::rec_t      q_rec;
  logic                q_pop;

  mtep_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  mtep_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .q_pop   (q_pop)
  );

  mtep_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[design/mtep_checker.sv]
`include "midi_track_event_parser_defines.svh"

module mtep_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [1:0] out_error_code,
  input logic [27:0] out_delta_ticks,
  input logic [7:0] out_status_byte,
  input logic [7:0] out_first_data
);

  // hold a stalled record
  `MTEP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_status_byte), "stalled record changed")

  // nothing follows a delivered error record
  `MTEP_ASSERT_NEXT(a_halt_after_err, out_valid && out_ready && out_kind == mtep_pkg::KIND_ERR, !out_valid, "record after error")

  `MTEP_ASSERT_NOW(a_err_code, out_valid, (out_kind == mtep_pkg::KIND_ERR) == (out_error_code != mtep_pkg::ERR_NONE), "kind and error code disagree")

  `MTEP_ASSERT_NOW(a_meta_shape, out_valid && out_kind == mtep_pkg::KIND_META, out_status_byte == mtep_pkg::META_STATUS && out_first_data == 8'h00, "malformed meta record")

  `MTEP_ASSERT_NOW(a_tag_err_shape, out_valid && out_kind == mtep_pkg::KIND_ERR && out_error_code == mtep_pkg::ERR_TAG, out_delta_ticks == '0 && out_status_byte == 8'h00, "tag error carries data")

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_error_code  (out_ch.error_code),
  .out_delta_ticks (out_ch.delta_ticks),
  .out_status_byte (out_ch.status_byte),
  .out_first_data  (out_ch.first_data)
);

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    ST_HEADER,
    ST_TAG,
    ST_LEN,
    ST_DELTA,
    ST_STATUS,
    ST_DATA1,
    ST_DATA2,
    ST_MTYPE,
    ST_MLEN,
    ST_MSKIP
  } parse_state_t;

  localparam logic [31:0] TRACK_TAG   = 32'h4D54726B;
  localparam logic [3:0]  HI_NOTE_OFF = 4'h8;
  localparam logic [3:0]  HI_PROGRAM  = 4'hC;
  localparam logic [3:0]  HI_PRESSURE = 4'hD;
  localparam logic [3:0]  HI_PITCH    = 4'hE;
  localparam logic [7:0]  SYSEX_FIRST = 8'hF0;
  localparam int          CALM_FROM   = 700;
  localparam int          CALM_TO     = 1200;
  localparam int          DRAIN_CYCLES = 24;

  logic clk;
  logic rst_n;

  mtep_byte_if in_if ();
  mtep_rec_if  out_if ();

  midi_track_event_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic [7:0]      file_bytes [$];
  logic [7:0]      track_body [$];
  int              event_ends [$];
  mtep_pkg::rec_t  expected_events [$];

  int cyc;
  int failures;
  int bytes_sent;
  int bytes_total;

  parse_state_t                 parse_state;
  int                           hdr_count;
  int                           field_idx;
  logic [31:0]                  bytes_left;
  logic [mtep_pkg::DELTA_W-1:0] delta_acc;
  logic [7:0]                   status_keep;
  logic [7:0]                   data_keep;
  logic [7:0]                   mtype_keep;
  logic [mtep_pkg::DELTA_W-1:0] meta_len;
  logic [mtep_pkg::DELTA_W-1:0] meta_left;
  logic                         halted;

  mtep_pkg::rec_t seen;
  mtep_pkg::rec_t want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("FAIL midi_track_event_parser");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic logic take_break();
    if (cyc >= CALM_FROM && cyc < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 14;
  endfunction

  function automatic string rec_text(input mtep_pkg::rec_t r);
    return $sformatf(
      "kind=%0d code=%0d delta=%0d status=%h d1=%h d2=%h mkind=%h msize=%0d end=%0b",
      r.kind, r.error_code, r.delta_ticks, r.status_byte, r.first_data,
      r.second_data, r.meta_kind, r.meta_size, r.track_end);
  endfunction

  // Parser prediction

  task automatic clear_parser();
    parse_state = (mtep_pkg::HEADER_BYTES == 0) ? ST_TAG : ST_HEADER;
    hdr_count   = 0;
    field_idx   = 0;
    bytes_left  = '0;
    delta_acc   = '0;
    status_keep = '0;
    data_keep   = '0;
    mtype_keep  = '0;
    meta_len    = '0;
    meta_left   = '0;
    halted      = 1'b0;
  endtask

  task automatic close_event(input logic is_meta, input logic [7:0] d1, input logic [7:0] d2);
    mtep_pkg::rec_t r;
    r = '0;
    r.error_code  = mtep_pkg::ERR_NONE;
    r.delta_ticks = delta_acc;
    r.track_end   = (bytes_left == 0);
    if (is_meta) begin
      r.kind        = mtep_pkg::KIND_META;
      r.status_byte = mtep_pkg::META_STATUS;
      r.meta_kind   = mtype_keep;
      r.meta_size   = meta_len;
    end else begin
      r.kind        = mtep_pkg::KIND_CHAN;
      r.status_byte = status_keep;
      r.first_data  = d1;
      r.second_data = d2;
    end
    expected_events.push_back(r);
    delta_acc   = '0;
    parse_state = r.track_end ? ST_TAG : ST_DELTA;
  endtask

  task automatic raise_fault(input mtep_pkg::err_t code,
                             input logic [mtep_pkg::DELTA_W-1:0] d,
                             input logic [7:0] s);
    mtep_pkg::rec_t r;
    r = '0;
    r.kind        = mtep_pkg::KIND_ERR;
    r.error_code  = code;
    r.delta_ticks = d;
    r.status_byte = s;
    expected_events.push_back(r);
    halted = 1'b1;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    if (halted) begin
      return;
    end
    if (parse_state >= ST_DELTA && bytes_left != 0) begin
      bytes_left = bytes_left - 1;
    end
    case (parse_state)
      ST_HEADER: begin
        hdr_count++;
        if (hdr_count >= mtep_pkg::HEADER_BYTES) begin
          hdr_count   = 0;
          parse_state = ST_TAG;
        end
      end
      ST_TAG: begin
        if (b != TRACK_TAG[31 - 8 * field_idx -: 8]) begin
          raise_fault(mtep_pkg::ERR_TAG, '0, '0);
        end else begin
          field_idx++;
          if (field_idx >= 4) begin
            field_idx   = 0;
            bytes_left  = '0;
            parse_state = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        bytes_left = {bytes_left[23:0], b};
        field_idx++;
        if (field_idx >= 4) begin
          field_idx   = 0;
          delta_acc   = '0;
          parse_state = (bytes_left == 0) ? ST_TAG : ST_DELTA;
        end
      end
      ST_DELTA: begin
        delta_acc = {delta_acc[mtep_pkg::DELTA_W-8:0], b[6:0]};
        if (!b[7]) begin
          parse_state = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (b == mtep_pkg::META_STATUS) begin
          status_keep = b;
          parse_state = ST_MTYPE;
        end else if (b[7:4] >= HI_NOTE_OFF && b[7:4] <= HI_PITCH) begin
          status_keep = b;
          parse_state = ST_DATA1;
        end else begin
          raise_fault(mtep_pkg::ERR_STATUS, delta_acc, b);
        end
      end
      ST_DATA1: begin
        if (status_keep[7:4] == HI_PROGRAM || status_keep[7:4] == HI_PRESSURE) begin
          close_event(1'b0, b, 8'h00);
        end else begin
          data_keep   = b;
          parse_state = ST_DATA2;
        end
      end
      ST_DATA2: begin
        close_event(1'b0, data_keep, b);
      end
      ST_MTYPE: begin
        mtype_keep  = b;
        meta_left   = '0;
        parse_state = ST_MLEN;
      end
      ST_MLEN: begin
        meta_left = {meta_left[mtep_pkg::DELTA_W-8:0], b[6:0]};
        if (!b[7]) begin
          meta_len = meta_left;
          if (meta_left == 0) begin
            close_event(1'b1, 8'h00, 8'h00);
          end else begin
            parse_state = ST_MSKIP;
          end
        end
      end
      ST_MSKIP: begin
        if (meta_left != 0) begin
          meta_left = meta_left - 1;
        end
        if (meta_left == 0) begin
          close_event(1'b1, 8'h00, 8'h00);
        end
      end
      default: begin
        parse_state = ST_TAG;
      end
    endcase
  endtask

  // Byte driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      clear_parser();
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.in_byte);
        bytes_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (file_bytes.size() != 0 && !take_break()) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= file_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Record monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen.kind        = mtep_pkg::kind_t'(out_if.kind);
        seen.error_code  = mtep_pkg::err_t'(out_if.error_code);
        seen.delta_ticks = out_if.delta_ticks;
        seen.status_byte = out_if.status_byte;
        seen.first_data  = out_if.first_data;
        seen.second_data = out_if.second_data;
        seen.meta_kind   = out_if.meta_kind;
        seen.meta_size   = out_if.meta_size;
        seen.track_end   = out_if.track_end;
        if (expected_events.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected record: %s", rec_text(seen));
          end
        end else begin
          want = expected_events.pop_front();
          if (seen.kind !== want.kind || seen.error_code !== want.error_code ||
              seen.delta_ticks !== want.delta_ticks ||
              seen.status_byte !== want.status_byte ||
              seen.first_data !== want.first_data || seen.second_data !== want.second_data ||
              seen.meta_kind !== want.meta_kind || seen.meta_size !== want.meta_size ||
              seen.track_end !== want.track_end) begin
            failures++;
            if (failures <= 10) begin
              $display("record mismatch at %0t", $realtime);
              $display("  expected %s", rec_text(want));
              $display("  actual   %s", rec_text(seen));
            end
          end
        end
      end
      out_if.ready <= !take_break();
    end
  end

  // File builder

  task automatic add_vlq(input logic [mtep_pkg::DELTA_W-1:0] v, input int extra);
    int n;
    logic [6:0] g;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) begin
      n++;
    end
    n += extra;
    for (int i = n - 1; i >= 0; i--) begin
      g = (i < 4) ? 7'(v >> (7 * i)) : 7'($urandom_range(0, 127));
      track_body.push_back({i != 0, g});
    end
  endtask

  task automatic add_chan(input logic [mtep_pkg::DELTA_W-1:0] delta, input int dx,
                          input logic [7:0] status,
                          input logic [7:0] d1, input logic [7:0] d2);
    add_vlq(delta, dx);
    track_body.push_back(status);
    track_body.push_back(d1);
    if (status[7:4] != HI_PROGRAM && status[7:4] != HI_PRESSURE) begin
      track_body.push_back(d2);
    end
    event_ends.push_back(track_body.size());
  endtask

  task automatic add_meta(input logic [mtep_pkg::DELTA_W-1:0] delta, input int dx,
                          input logic [7:0] mtype,
                          input int size, input int sx);
    add_vlq(delta, dx);
    track_body.push_back(mtep_pkg::META_STATUS);
    track_body.push_back(mtype);
    add_vlq(mtep_pkg::DELTA_W'(size), sx);
    repeat (size) track_body.push_back(8'($urandom));
    event_ends.push_back(track_body.size());
  endtask

  // Cut the body after the event in which the length runs out.
  task automatic emit_track(input logic [31:0] len);
    int cut;
    cut = track_body.size();
    if (len == 0) begin
      cut = 0;
    end else begin
      foreach (event_ends[k]) begin
        if (event_ends[k] >= len && cut == track_body.size()) begin
          cut = event_ends[k];
        end
      end
    end
    for (int k = 0; k < 4; k++) file_bytes.push_back(TRACK_TAG[31 - 8 * k -: 8]);
    for (int k = 0; k < 4; k++) file_bytes.push_back(len[31 - 8 * k -: 8]);
    for (int k = 0; k < cut; k++) file_bytes.push_back(track_body[k]);
    track_body.delete();
    event_ends.delete();
  endtask

  task automatic add_random_track();
    int n;
    int pick;
    int total;
    logic [mtep_pkg::DELTA_W-1:0] delta;
    int dx;
    int size;
    int sx;
    n = $urandom_range(1, 8);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        delta = $urandom_range(0, 127);
      end else if (pick <= 7) begin
        delta = $urandom_range(0, 16383);
      end else if (pick == 8) begin
        delta = mtep_pkg::DELTA_W'($urandom);
      end else begin
        delta = '0;
      end
      dx = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 3) == 0) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 12);
        sx   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
        add_meta(delta, dx, 8'($urandom), size, sx);
      end else begin
        add_chan(delta, dx, {4'($urandom_range(8, 14)), 4'($urandom)},
                 8'($urandom), 8'($urandom));
      end
    end
    total = track_body.size();
    pick  = $urandom_range(0, 19);
    if (pick <= 1) begin
      emit_track(32'd0);
    end else if (pick <= 4) begin
      emit_track($urandom_range(1, total));
    end else begin
      emit_track(total);
    end
  endtask

  initial begin : stimulus
    int k;
    logic [7:0] bad;

    for (k = 0; k < mtep_pkg::HEADER_BYTES; k++) begin
      file_bytes.push_back((k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom));
    end

    emit_track(32'd0);

    add_chan('0, 0, 8'h90, 8'h00, 8'h7F);
    add_chan(28'h0FFFFFFF, 0, 8'h80, 8'hFF, 8'h80);
    add_chan(28'h123, 3, 8'hCF, 8'hFF, 8'h00);
    add_chan(28'd1, 0, 8'hD0, 8'h80, 8'h00);
    add_chan(28'd5, 0, 8'hA5, 8'h01, 8'h02);
    add_chan(28'd7, 0, 8'hB3, 8'h40, 8'h7F);
    add_chan(28'd127, 0, 8'hEF, 8'h00, 8'h40);
    add_meta('0, 0, 8'h51, 0, 0);
    add_meta(28'd128, 0, 8'h03, 3, 3);
    add_meta('0, 0, 8'h2F, 0, 0);
    emit_track(track_body.size());

    // length runs out at the status byte of the first event
    add_chan('0, 0, 8'h92, 8'h01, 8'h02);
    add_meta(28'd300, 0, 8'h01, 5, 0);
    emit_track(32'd2);

    // length runs out inside the meta payload
    add_meta('0, 0, 8'h7F, 10, 0);
    emit_track(32'd5);

    while (file_bytes.size() < 1750) begin
      add_random_track();
    end

    if ($urandom_range(0, 1) == 0) begin
      k = $urandom_range(0, 3);
      for (int j = 0; j < k; j++) file_bytes.push_back(TRACK_TAG[31 - 8 * j -: 8]);
      file_bytes.push_back(TRACK_TAG[31 - 8 * k -: 8] ^ 8'($urandom_range(1, 255)));
    end else begin
      add_chan(28'd3, 0, 8'h9A, 8'($urandom), 8'($urandom));
      add_meta(28'd0, 0, 8'h06, 2, 0);
      add_vlq(mtep_pkg::DELTA_W'($urandom_range(0, 20000)), 0);
      bad = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                        : SYSEX_FIRST + 8'($urandom_range(0, 14));
      track_body.push_back(bad);
      emit_track(32'hFFFF_FFFF);
    end
    repeat (12) file_bytes.push_back(8'($urandom));

    bytes_total = file_bytes.size();

    wait (rst_n === 1'b1);
    while (bytes_sent < bytes_total) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("PASS midi_track_event_parser");
    end else begin
      $display("FAIL midi_track_event_parser");
    end
    $finish;
  end

endmodule
